[rtl/core/ffpfa_pkg.sv]
// Shared types and constants of the first-fit page frame allocator.
package ffpfa_pkg;

   localparam int PAGES_DEF = 1024;
   localparam int PAGE_IDX_W = 10;
   localparam int COUNT_W = 11;
   localparam int SPAN_W = 12;

   localparam logic [2:0] KIND_CLEAR = 3'd0;
   localparam logic [2:0] KIND_MARK = 3'd1;
   localparam logic [2:0] KIND_LINK = 3'd2;
   localparam logic [2:0] KIND_ALLOC = 3'd3;
   localparam logic [2:0] KIND_FREE = 3'd4;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_NOFIT,
      STAT_BADFREE,
      STAT_NOTREADY
   } ffpfa_status_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [PAGE_IDX_W-1:0] start_page;
      logic [COUNT_W-1:0] page_count;
      logic avail_flag;
   } ffpfa_req_type;

   typedef struct packed {
      ffpfa_status_type status;
      logic [PAGE_IDX_W-1:0] frame_page;
   } ffpfa_rsp_type;

endpackage

[rtl/core/ffpfa_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module ffpfa_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/first_fit_page_frame_allocator_core.sv]
// Top level of the first-fit page frame allocator with coalescing on free.
//
// Items arrive on req_valid/req_stall/req_data; every item gives exactly one
// result on rsp_valid/rsp_stall/rsp_data (status and page index).
// One item is worked on at a time; req_stall is high while it is in progress.
// The page table lives in one RAM (avail, alloc, next index per page) with a
// registered read; walks follow the block chain at one entry a cycle.
// Work per item:
//   clear: all PAGES entries     mark: the clipped page range     link: all PAGES entries
//   allocate: walks the blocks, with one more write on a split
//   free: walks the blocks, then merges with free neighbours
//   rejected or unknown kinds: straight to the result
// The result register frees the request side: a new item is accepted while
// an earlier result waits under rsp_stall; a finished item then holds in
// its last state until the output register is taken.
// After reset a clearing pass writes all PAGES entries to zero, one a cycle,
// during which no item is accepted; it produces no result.
module first_fit_page_frame_allocator_core #(
   parameter int PAGES = ffpfa_pkg::PAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  ffpfa_pkg::ffpfa_req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output ffpfa_pkg::ffpfa_rsp_type rsp_data
);

   import ffpfa_pkg::*;

   localparam int PW = $clog2(PAGES);
   localparam int EW = PW + 2;
   localparam int CW = (PW + 1 > SPAN_W) ? PW + 1 : SPAN_W;
   localparam logic [PW-1:0] LAST_PG = PW'(PAGES - 1);
   localparam logic [CW-1:0] PAGES_C = CW'(PAGES);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MARK,
      S_LINK,
      S_LINK_END,
      S_ALLOC_START,
      S_ALLOC_WALK,
      S_ALLOC_SPLIT,
      S_FREE_START,
      S_FREE_WALK,
      S_FREE_T,
      S_FREE_N,
      S_FREE_WR,
      S_FREE_WP,
      S_RESULT
   } state_type;

   state_type state_ff, state_in;
   ffpfa_req_type req_ff, req_in;
   logic built_ff, built_in;
   logic report_ff, report_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] end_ff, end_in;
   logic pv_ff, pv_in;
   logic [PW-1:0] pa_ff, pa_in;
   logic [PW-1:0] cur_ff, cur_in;
   logic cur_avail_ff, cur_avail_in;
   logic [PW-1:0] nx_ff, nx_in;
   logic [PW-1:0] aux_ff, aux_in;
   logic p_avail_ff, p_avail_in;
   logic p_alloc_ff, p_alloc_in;
   logic t_avail_ff, t_avail_in;
   logic nm_ff, nm_in;
   ffpfa_status_type res_status_ff, res_status_in;
   logic [PW-1:0] res_page_ff, res_page_in;
   logic rsp_valid_ff, rsp_valid_in;
   ffpfa_rsp_type rsp_data_ff, rsp_data_in;

   logic wr_en;
   logic [PW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [PW-1:0] rd_addr;
   logic [EW-1:0] rd_data;

   logic rd_avail;
   logic rd_alloc;
   logic [PW-1:0] rd_next;
   logic out_free;
   logic issue;
   logic pm;
   logic [CW-1:0] span;
   logic [PW-1:0] split;
   logic [PW-1:0] free_pg;

   function automatic logic [EW-1:0] mk_entry(input logic avail, input logic alloc,
                                              input logic [PW-1:0] next);
      return {avail, alloc, next};
   endfunction

   ffpfa_ram #(
      .WIDTH(EW),
      .DEPTH(PAGES)
   ) u_table (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_avail = rd_data[EW-1];
   assign rd_alloc = rd_data[EW-2];
   assign rd_next = rd_data[PW-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pm = p_avail_ff && !p_alloc_ff;
   assign span = CW'(req_data.start_page) + CW'(req_data.page_count);
   assign split = cur_ff + PW'(req_ff.page_count);
   assign free_pg = PW'(req_ff.start_page);

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      built_in = built_ff;
      report_in = report_ff;
      ptr_in = ptr_ff;
      end_in = end_ff;
      pv_in = 1'b0;
      pa_in = pa_ff;
      cur_in = cur_ff;
      cur_avail_in = cur_avail_ff;
      nx_in = nx_ff;
      aux_in = aux_ff;
      p_avail_in = p_avail_ff;
      p_alloc_in = p_alloc_ff;
      t_avail_in = t_avail_ff;
      nm_in = nm_ff;
      res_status_in = res_status_ff;
      res_page_in = res_page_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_addr = '0;
      issue = 1'b0;
      req_stall = (state_ff != S_IDLE);

      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = ptr_ff[PW-1:0];
            ptr_in = ptr_ff + CW'(1);
            built_in = 1'b0;
            if (ptr_ff[PW-1:0] == LAST_PG) begin
               state_in = report_ff ? S_RESULT : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               res_status_in = STAT_OK;
               res_page_in = '0;
               ptr_in = '0;
               unique case (req_data.kind)
                  KIND_CLEAR: begin
                     report_in = 1'b1;
                     state_in = S_CLEAR;
                  end
                  KIND_MARK: begin
                     built_in = 1'b0;
                     ptr_in = CW'(req_data.start_page);
                     end_in = (span > PAGES_C) ? PAGES_C : span;
                     state_in = S_MARK;
                  end
                  KIND_LINK: begin
                     state_in = S_LINK;
                  end
                  KIND_ALLOC: begin
                     if (!built_ff || req_data.page_count == '0) begin
                        res_status_in = STAT_NOTREADY;
                        state_in = S_RESULT;
                     end else begin
                        state_in = S_ALLOC_START;
                     end
                  end
                  KIND_FREE: begin
                     if (!built_ff) begin
                        res_status_in = STAT_NOTREADY;
                        state_in = S_RESULT;
                     end else if (req_data.start_page == '0 ||
                                  CW'(req_data.start_page) >= CW'(LAST_PG)) begin
                        res_status_in = STAT_BADFREE;
                        state_in = S_RESULT;
                     end else begin
                        state_in = S_FREE_START;
                     end
                  end
                  default: begin
                     state_in = S_RESULT;
                  end
               endcase
            end
         end
         S_MARK: begin
            issue = (ptr_ff < end_ff);
            if (issue) begin
               rd_addr = ptr_ff[PW-1:0];
               pv_in = 1'b1;
               pa_in = ptr_ff[PW-1:0];
               ptr_in = ptr_ff + CW'(1);
            end
            if (pv_ff) begin
               wr_en = 1'b1;
               wr_addr = pa_ff;
               wr_data = mk_entry(req_ff.avail_flag, rd_alloc, rd_next);
            end
            if (!issue && !pv_ff) begin
               state_in = S_RESULT;
            end
         end
         S_LINK: begin
            issue = (ptr_ff < PAGES_C);
            if (issue) begin
               rd_addr = ptr_ff[PW-1:0];
               pv_in = 1'b1;
               pa_in = ptr_ff[PW-1:0];
               ptr_in = ptr_ff + CW'(1);
            end
            // heads are written once their successor is known
            if (pv_ff) begin
               if (pa_ff == '0) begin
                  cur_in = '0;
                  cur_avail_in = rd_avail;
               end else if (rd_avail != cur_avail_ff) begin
                  wr_en = 1'b1;
                  wr_addr = cur_ff;
                  wr_data = mk_entry(cur_avail_ff, 1'b0, pa_ff);
                  cur_in = pa_ff;
                  cur_avail_in = rd_avail;
               end else begin
                  wr_en = 1'b1;
                  wr_addr = pa_ff;
                  wr_data = mk_entry(rd_avail, 1'b0, '0);
               end
            end
            if (!issue && !pv_ff) begin
               state_in = S_LINK_END;
            end
         end
         S_LINK_END: begin
            wr_en = 1'b1;
            wr_addr = cur_ff;
            wr_data = mk_entry(cur_avail_ff, 1'b0, LAST_PG);
            built_in = 1'b1;
            state_in = S_RESULT;
         end
         S_ALLOC_START: begin
            rd_addr = '0;
            cur_in = '0;
            state_in = S_ALLOC_WALK;
         end
         S_ALLOC_WALK: begin
            if (cur_ff == LAST_PG || rd_next <= cur_ff || rd_next > LAST_PG) begin
               res_status_in = STAT_NOFIT;
               state_in = S_RESULT;
            end else if (rd_avail && !rd_alloc &&
                         CW'(rd_next - cur_ff) >= CW'(req_ff.page_count)) begin
               wr_en = 1'b1;
               wr_addr = cur_ff;
               wr_data = mk_entry(rd_avail, 1'b1, split);
               res_page_in = cur_ff;
               if (split != rd_next) begin
                  rd_addr = split;
                  aux_in = split;
                  nx_in = rd_next;
                  state_in = S_ALLOC_SPLIT;
               end else begin
                  state_in = S_RESULT;
               end
            end else begin
               rd_addr = rd_next;
               cur_in = rd_next;
            end
         end
         S_ALLOC_SPLIT: begin
            wr_en = 1'b1;
            wr_addr = aux_ff;
            wr_data = mk_entry(rd_avail, 1'b0, nx_ff);
            state_in = S_RESULT;
         end
         S_FREE_START: begin
            rd_addr = '0;
            cur_in = '0;
            state_in = S_FREE_WALK;
         end
         S_FREE_WALK: begin
            if (cur_ff == LAST_PG) begin
               res_status_in = STAT_BADFREE;
               state_in = S_RESULT;
            end else if (rd_next == free_pg) begin
               p_avail_in = rd_avail;
               p_alloc_in = rd_alloc;
               rd_addr = free_pg;
               state_in = S_FREE_T;
            end else if (rd_next <= cur_ff || rd_next > LAST_PG) begin
               res_status_in = STAT_BADFREE;
               state_in = S_RESULT;
            end else begin
               rd_addr = rd_next;
               cur_in = rd_next;
            end
         end
         S_FREE_T: begin
            if (!rd_alloc || rd_next > LAST_PG) begin
               res_status_in = STAT_BADFREE;
               state_in = S_RESULT;
            end else begin
               t_avail_in = rd_avail;
               nx_in = rd_next;
               nm_in = 1'b0;
               if (rd_next != LAST_PG) begin
                  rd_addr = rd_next;
                  state_in = S_FREE_N;
               end else begin
                  state_in = S_FREE_WR;
               end
            end
         end
         S_FREE_N: begin
            nm_in = rd_avail && !rd_alloc;
            aux_in = rd_next;
            state_in = S_FREE_WR;
         end
         S_FREE_WR: begin
            wr_en = 1'b1;
            wr_addr = free_pg;
            wr_data = mk_entry(t_avail_ff, 1'b0, (nm_ff && !pm) ? aux_ff : nx_ff);
            state_in = pm ? S_FREE_WP : S_RESULT;
         end
         S_FREE_WP: begin
            wr_en = 1'b1;
            wr_addr = cur_ff;
            wr_data = mk_entry(p_avail_ff, p_alloc_ff, nm_ff ? aux_ff : nx_ff);
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status = res_status_ff;
               rsp_data_in.frame_page = PAGE_IDX_W'(res_page_ff);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         built_ff <= 1'b0;
         report_ff <= 1'b0;
         ptr_ff <= '0;
         pv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         built_ff <= built_in;
         report_ff <= report_in;
         ptr_ff <= ptr_in;
         pv_ff <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      end_ff <= end_in;
      pa_ff <= pa_in;
      cur_ff <= cur_in;
      cur_avail_ff <= cur_avail_in;
      nx_ff <= nx_in;
      aux_ff <= aux_in;
      p_avail_ff <= p_avail_in;
      p_alloc_ff <= p_alloc_in;
      t_avail_ff <= t_avail_in;
      nm_ff <= nm_in;
      res_status_ff <= res_status_in;
      res_page_ff <= res_page_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
